### design/tal_pkg.sv
// Shared types and constants for the tile availability lookup unit.
`default_nettype none

package tal_pkg;

    localparam int COORD_BITS = 20;
    localparam int LEVEL_W    = 5;
    localparam int INDEX_W    = 61;
    localparam int LEN_W      = 13;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd20;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic SCHEME_QUAD = 1'b0;
    localparam logic SCHEME_OCT  = 1'b1;

    localparam logic [1:0] SEL_TILE    = 2'd0;
    localparam logic [1:0] SEL_CONTENT = 2'd1;
    localparam logic [1:0] SEL_CHILD   = 2'd2;

    localparam logic [1:0] MODE_STREAM = 2'd0;
    localparam logic [1:0] MODE_FALSE  = 2'd1;
    localparam logic [1:0] MODE_TRUE   = 2'd2;

    localparam logic [2:0] REG_SCHEME        = 3'd0;
    localparam logic [2:0] REG_TILE_MODE     = 3'd1;
    localparam logic [2:0] REG_CONTENT_MODE  = 3'd2;
    localparam logic [2:0] REG_CHILD_MODE    = 3'd3;
    localparam logic [2:0] REG_TILE_BYTES    = 3'd4;
    localparam logic [2:0] REG_CONTENT_BYTES = 3'd5;
    localparam logic [2:0] REG_CHILD_BYTES   = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

    // Picks the constant value of a mode, or the stream bit in stream mode.
    // The unused code three reads as constant true.
    function automatic logic mode_bit(input logic [1:0] mode, input logic stream);
        logic res;
        case (mode)
            MODE_STREAM: res = stream;
            MODE_FALSE:  res = 1'b0;
            default:     res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

### design/tile_availability_lookup_unit.sv
// Top level of the tile availability lookup unit.
// A load word leaves the unit idle, so it can take another word in the next cycle.
// A query word occupies the unit while the index is formed and registered, the
// bitstream RAM is read, and then the result word lands in the output register.
// A new word is taken only after that, and the output register waits while a result word is stalled.
// Reset is synchronous and clears the sequencer, output valid and configuration registers.
`default_nettype none

module tile_availability_lookup_unit #(
    parameter int STREAM_BYTES = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_op,
    input  wire logic [1:0]                       i_stream_sel,
    input  wire logic [11:0]                      i_byte_addr,
    input  wire logic [7:0]                       i_byte_data,
    input  wire logic [tal_pkg::LEVEL_W-1:0]      i_level,
    input  wire logic [tal_pkg::COORD_BITS-1:0]   i_coord_x,
    input  wire logic [tal_pkg::COORD_BITS-1:0]   i_coord_y,
    input  wire logic [tal_pkg::COORD_BITS-1:0]   i_coord_z,

    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [tal_pkg::INDEX_W-1:0]      o_bit_index,
    output logic                                  o_tile_available,
    output logic                                  o_content_available,
    output logic                                  o_child_available,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [4:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready
);

    import tal_pkg::*;

    localparam int AW = (STREAM_BYTES > 1) ? $clog2(STREAM_BYTES) : 1;
    localparam logic [63:0] DEPTH64 = 64'(STREAM_BYTES);

    // Configuration registers.
    logic             r_scheme;
    logic [1:0]       r_tile_mode;
    logic [1:0]       r_content_mode;
    logic [1:0]       r_child_mode;
    logic [LEN_W-1:0] r_tile_bytes;
    logic [LEN_W-1:0] r_content_bytes;
    logic [LEN_W-1:0] r_child_bytes;

    logic       cfg_we;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme        <= SCHEME_QUAD;
            r_tile_mode     <= MODE_STREAM;
            r_content_mode  <= MODE_STREAM;
            r_child_mode    <= MODE_STREAM;
            r_tile_bytes    <= '0;
            r_content_bytes <= '0;
            r_child_bytes   <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_SCHEME:        r_scheme        <= pwdata[0];
                REG_TILE_MODE:     r_tile_mode     <= pwdata[1:0];
                REG_CONTENT_MODE:  r_content_mode  <= pwdata[1:0];
                REG_CHILD_MODE:    r_child_mode    <= pwdata[1:0];
                REG_TILE_BYTES:    r_tile_bytes    <= pwdata[LEN_W-1:0];
                REG_CONTENT_BYTES: r_content_bytes <= pwdata[LEN_W-1:0];
                REG_CHILD_BYTES:   r_child_bytes   <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SCHEME:        prdata = {31'b0, r_scheme};
            REG_TILE_MODE:     prdata = {30'b0, r_tile_mode};
            REG_CONTENT_MODE:  prdata = {30'b0, r_content_mode};
            REG_CHILD_MODE:    prdata = {30'b0, r_child_mode};
            REG_TILE_BYTES:    prdata = {19'b0, r_tile_bytes};
            REG_CONTENT_BYTES: prdata = {19'b0, r_content_bytes};
            REG_CHILD_BYTES:   prdata = {19'b0, r_child_bytes};
            default:           prdata = '0;
        endcase
    end

    // Input side.
    t_state r_state, n_state;

    logic in_accept;
    logic load_acc;
    logic query_acc;
    logic load_in_range;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign in_accept     = i_in_valid && !o_in_stall;
    assign load_acc      = in_accept && (i_op == OP_LOAD);
    assign query_acc     = in_accept && (i_op == OP_QUERY);
    assign load_in_range = (64'(i_byte_addr) < DEPTH64);

    logic [INDEX_W-1:0] idx_calc;

    tal_index_calc u_index (
        .i_scheme    (r_scheme),
        .i_level     (i_level),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .o_bit_index (idx_calc)
    );

    logic [INDEX_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (query_acc) begin
            r_idx <= idx_calc;
        end
    end

    // Stream RAMs share one address: loads only happen while no query reads.
    logic [63:0]   load_addr_w;
    logic [AW-1:0] ram_addr;
    logic          ram_re;
    logic          we_tile, we_content, we_child;
    logic [7:0]    rd_tile, rd_content, rd_child;

    assign load_addr_w = 64'(i_byte_addr);
    assign ram_re      = (r_state == ST_READ);
    assign ram_addr    = ram_re ? r_idx[AW+2:3] : load_addr_w[AW-1:0];
    assign we_tile     = load_acc && load_in_range && (i_stream_sel == SEL_TILE);
    assign we_content  = load_acc && load_in_range && (i_stream_sel == SEL_CONTENT);
    assign we_child    = load_acc && load_in_range && (i_stream_sel == SEL_CHILD);

    tal_ram #(.WIDTH(8), .DEPTH(STREAM_BYTES)) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (we_tile),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_byte_data),
        .o_rdata (rd_tile)
    );

    tal_ram #(.WIDTH(8), .DEPTH(STREAM_BYTES)) u_content_ram (
        .i_clk   (i_clk),
        .i_we    (we_content),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_byte_data),
        .o_rdata (rd_content)
    );

    tal_ram #(.WIDTH(8), .DEPTH(STREAM_BYTES)) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (we_child),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_byte_data),
        .o_rdata (rd_child)
    );

    // Length checks run alongside the RAM read; a length past the store is
    // clipped to the store size.
    logic [INDEX_W-4:0] byte_idx;
    logic               r_tile_in, r_content_in, r_child_in;

    assign byte_idx = r_idx[INDEX_W-1:3];

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_tile_in    <= (64'(byte_idx) < 64'(r_tile_bytes))
                            && (64'(byte_idx) < DEPTH64);
            r_content_in <= (64'(byte_idx) < 64'(r_content_bytes))
                            && (64'(byte_idx) < DEPTH64);
            r_child_in   <= (64'(byte_idx) < 64'(r_child_bytes))
                            && (64'(byte_idx) < DEPTH64);
        end
    end

    logic tile_bit, content_bit, child_bit;
    logic tile_res, content_res, child_res;

    always_comb begin
        tile_bit    = r_tile_in && rd_tile[r_idx[2:0]];
        content_bit = r_content_in && rd_content[r_idx[2:0]];
        child_bit   = r_child_in && rd_child[r_idx[2:0]];
        tile_res    = mode_bit(r_tile_mode, tile_bit);
        // An empty content stream follows tile availability, unless the mode is constant.
        content_res = mode_bit(r_content_mode,
                               (r_content_bytes == '0) ? tile_res : content_bit);
        child_res   = mode_bit(r_child_mode, child_bit);
    end

    // Sequencer and output register.
    logic r_out_valid;
    logic out_load;

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (query_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic [INDEX_W-1:0] r_bit_index;
    logic               r_tile_avail, r_content_avail, r_child_avail;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_bit_index     <= r_idx;
            r_tile_avail    <= tile_res;
            r_content_avail <= content_res;
            r_child_avail   <= child_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_bit_index         = r_bit_index;
    assign o_tile_available    = r_tile_avail;
    assign o_content_available = r_content_avail;
    assign o_child_available   = r_child_avail;

    // A query always moves on to the RAM read in the following cycle.
    a_query_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_acc |=> (r_state == ST_READ))
        else $error("accepted query did not start a RAM read");

    // A RAM read is always followed by the result stage in the next cycle.
    a_read_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_DONE))
        else $error("RAM read not followed by result stage");

    // A load never collides with a query read on the shared RAM address.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_re && (we_tile || we_content || we_child)))
        else $error("RAM write during query read");

    // Finishing a query leaves a result word waiting and frees the input.
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && !o_in_stall))
        else $error("finished query did not reach the output register");

    // A load word never produces a result word.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_acc && !o_out_valid) |=> !o_out_valid)
        else $error("load produced a result word");

endmodule

`default_nettype wire

### design/tal_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module tal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/tal_index_calc.sv
// Bit index of a tile: tiles on earlier levels plus the Morton code of its coordinates.
`default_nettype none

module tal_index_calc (
    input  wire logic                             i_scheme,
    input  wire logic [tal_pkg::LEVEL_W-1:0]      i_level,
    input  wire logic [tal_pkg::COORD_BITS-1:0]   i_coord_x,
    input  wire logic [tal_pkg::COORD_BITS-1:0]   i_coord_y,
    input  wire logic [tal_pkg::COORD_BITS-1:0]   i_coord_z,
    output logic      [tal_pkg::INDEX_W-1:0]      o_bit_index
);

    import tal_pkg::*;

    logic [LEVEL_W-1:0] lvl;
    logic [INDEX_W-1:0] tiles_above;
    logic [INDEX_W-1:0] morton;

    // The count of tiles on earlier levels is a repunit in base 4 or 8, so it is
    // one set bit per level below the queried one.
    always_comb begin
        lvl         = (i_level > LEVEL_MAX) ? LEVEL_MAX : i_level;
        tiles_above = '0;
        morton      = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            if (i_scheme == SCHEME_QUAD) begin
                tiles_above[2*i] = (LEVEL_W'(i) < lvl);
                morton[2*i]      = i_coord_x[i];
                morton[2*i+1]    = i_coord_y[i];
            end else begin
                tiles_above[3*i] = (LEVEL_W'(i) < lvl);
                morton[3*i]      = i_coord_x[i];
                morton[3*i+1]    = i_coord_y[i];
                morton[3*i+2]    = i_coord_z[i];
            end
        end
        o_bit_index = tiles_above + morton;
    end

endmodule

`default_nettype wire
